// ----- src/grey_dither_sprite_packer_core_defines.svh -----
// assertion macros shared by the checker
`ifndef GREY_DITHER_SPRITE_PACKER_CORE_DEFINES_SVH
`define GREY_DITHER_SPRITE_PACKER_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define GDSP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define GDSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/gdsp_pkg.sv -----
package gdsp_pkg;

    // level code: 0 white, 1..3 greys, black outside the 2-bit range
    typedef logic [2:0] t_code;

    localparam t_code CODE_WHITE = 3'd0;
    localparam t_code CODE_GREY3 = 3'd1;
    localparam t_code CODE_GREY2 = 3'd2;
    localparam t_code CODE_GREY1 = 3'd3;
    localparam t_code CODE_BLACK = 3'd4;

    localparam int NUM_BANDS = 8;
    localparam int THR_W     = 13;

    typedef logic signed [THR_W-1:0] t_thr;
    typedef t_thr t_thr_array [NUM_BANDS];

    localparam t_code DARKER [NUM_BANDS] = '{
        CODE_BLACK, CODE_BLACK, CODE_GREY1, CODE_GREY1,
        CODE_GREY2, CODE_GREY2, CODE_GREY3, CODE_GREY3
    };
    localparam t_code LIGHTER [NUM_BANDS] = '{
        CODE_BLACK, CODE_GREY1, CODE_GREY1, CODE_GREY2,
        CODE_GREY2, CODE_GREY3, CODE_GREY3, CODE_WHITE
    };

    // configuration
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 9;
    localparam logic [CFG_INDEX_W-1:0] CFG_BAND_BASE  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BAND_WIDTH = 1'd1;

    localparam logic signed [8:0] BAND_BASE_RESET  = 9'sd0;
    localparam logic [7:0]        BAND_WIDTH_RESET = 8'd25;

    // sum/3 as (sum * 683) >> 11, exact for sums up to 765
    localparam logic [9:0] DIV3_MUL   = 10'd683;
    localparam int         DIV3_SHIFT = 11;

    // pixel after the input register
    typedef struct packed {
        logic [7:0] grey;
        logic       same;       // column and row parity equal
        logic [1:0] pos;        // pixel position within the group of four
        logic       emit;
        logic       frame;
        logic [5:0] row_idx;
        logic [2:0] byte_col;
    } t_pix;

endpackage

// ----- src/gdsp_classify.sv -----
module gdsp_classify
    import gdsp_pkg::*;
(
    input  logic [7:0] i_grey,
    input  logic       i_same,
    input  t_thr_array i_thr,
    output t_code      o_code
);

    t_thr                 grey_s;
    logic [NUM_BANDS-1:0] below;

    assign grey_s = $signed({5'b0, i_grey});

    always_comb begin
        for (int k = 0; k < NUM_BANDS; k++) begin
            below[k] = grey_s < i_thr[k];
        end
    end

    // lowest band that the level falls under wins; odd bands are the dithered ones
    always_comb begin
        o_code = CODE_WHITE;
        for (int k = NUM_BANDS - 1; k >= 0; k--) begin
            if (below[k]) begin
                if (k[0] == 1'b0 || i_same) begin
                    o_code = DARKER[3'(k)];
                end else begin
                    o_code = LIGHTER[3'(k)];
                end
            end
        end
    end

endmodule

// ----- src/grey_dither_sprite_packer_core.sv -----
// grey-level dither packer for 2-bit multicolour sprite bytes
//
// s_* takes one rgb pixel per item in raster order: s_tdata holds red, green,
// blue; s_tuser marks the first pixel of an image and restarts row, column
// and the byte being built. every fourth pixel of a row (and the last pixel
// of a row whose width is not a multiple of four) closes a group, and one
// item leaves on m_* with the colour byte, outline byte, row and byte column.
// the config port sets band base and band width; write it only while idle.
//
// throughput: one pixel per cycle while no closing pixel is held. a group's
// result shows on m_tvalid once its last pixel has passed the input register
// (grey level into it) and then the output register (classify and pack into it).
// reset clears counters, accumulators and both valid flags and loads the
// band defaults. while the receiver stalls, the pending result holds and
// pixels that do not close a group keep flowing; a closing pixel waits in
// the input register, and s_tready drops once that register is blocked.
module grey_dither_sprite_packer_core
    import gdsp_pkg::*;
#(
    parameter int IMAGE_WIDTH  = 24,
    parameter int IMAGE_HEIGHT = 42
)
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [23:0]            s_tdata,   // red[7:0], green[15:8], blue[23:16]
    input  logic                   s_tuser,   // frame_start

    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [31:0]            m_tdata    // colour_byte[7:0], outline_byte[15:8],
                                              // row_index[21:16], byte_column[24:22], 0
);

    localparam int COL_W = $clog2(IMAGE_WIDTH);
    localparam int ROW_W = (IMAGE_HEIGHT > 1) ? $clog2(IMAGE_HEIGHT) : 1;
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(IMAGE_WIDTH - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(IMAGE_HEIGHT - 1);

    // configuration
    logic signed [8:0] r_band_base;
    logic [7:0]        r_band_width;
    t_thr_array        r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band_base  <= BAND_BASE_RESET;
            r_band_width <= BAND_WIDTH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BAND_BASE:  r_band_base  <= $signed(i_cfg_data);
                CFG_BAND_WIDTH: r_band_width <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // thresholds are registered from the config registers and follow them in the next cycle
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_BANDS; k++) begin
            r_thr[k] <= THR_W'(r_band_base) + THR_W'(r_band_width) * THR_W'(k + 1);
        end
    end

    // input side: position counters and grey level
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] col_cur;
    logic [ROW_W-1:0] row_cur;
    logic [8:0]       col_ext;
    logic [8:0]       row_ext;
    logic             row_end;
    logic [9:0]       sum;
    logic [19:0]      prod;
    logic             s_accept;
    t_pix             n_s1;

    t_pix             r_s1;
    logic             r_s1_valid;
    logic             s1_move;
    logic             out_free;

    assign s_accept = s_tvalid && s_tready;
    assign col_cur  = s_tuser ? '0 : r_col;
    assign row_cur  = s_tuser ? '0 : r_row;
    assign col_ext  = 9'(col_cur);
    assign row_ext  = 9'(row_cur);
    assign row_end  = (col_cur == COL_LAST);

    assign sum  = 10'(s_tdata[7:0]) + 10'(s_tdata[15:8]) + 10'(s_tdata[23:16]);
    assign prod = 20'(sum) * 20'(DIV3_MUL);

    always_comb begin
        n_s1.grey     = prod[DIV3_SHIFT +: 8];
        n_s1.same     = ~(col_cur[0] ^ row_cur[0]);
        n_s1.pos      = col_ext[1:0];
        n_s1.emit     = (col_ext[1:0] == 2'b11) || row_end;
        n_s1.frame    = s_tuser;
        n_s1.row_idx  = row_ext[5:0];
        n_s1.byte_col = col_ext[4:2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (s_accept) begin
            if (row_end) begin
                r_col <= '0;
                r_row <= (row_cur == ROW_LAST) ? '0 : row_cur + 1'b1;
            end else begin
                r_col <= col_cur + 1'b1;
                r_row <= row_cur;
            end
        end
    end

    // a pixel that does not close a group never waits for the output side
    assign out_free = !m_tvalid || m_tready;
    assign s1_move  = r_s1_valid && (!r_s1.emit || out_free);
    assign s_tready = !r_s1_valid || s1_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_tready) begin
            r_s1_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1 <= n_s1;
        end
    end

    // classify and pack
    t_code      code;
    logic [1:0] colour_pair;
    logic [1:0] outline_pair;
    logic [2:0] shift;
    logic [7:0] colour_base;
    logic [7:0] outline_base;
    logic [7:0] n_colour_acc;
    logic [7:0] n_outline_acc;
    logic [7:0] r_colour_acc;
    logic [7:0] r_outline_acc;
    logic       r_m_tvalid;
    logic [31:0] r_m_tdata;

    gdsp_classify u_classify (
        .i_grey (r_s1.grey),
        .i_same (r_s1.same),
        .i_thr  (r_thr),
        .o_code (code)
    );

    assign colour_pair   = (code == CODE_BLACK) ? 2'b00 : code[1:0];
    assign outline_pair  = (code == CODE_BLACK) ? 2'b11 : 2'b00;
    assign shift         = {~r_s1.pos, 1'b0};
    assign colour_base   = r_s1.frame ? 8'h00 : r_colour_acc;
    assign outline_base  = r_s1.frame ? 8'h00 : r_outline_acc;
    assign n_colour_acc  = colour_base | (8'(colour_pair) << shift);
    assign n_outline_acc = outline_base | (8'(outline_pair) << shift);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_colour_acc  <= 8'h00;
            r_outline_acc <= 8'h00;
        end else if (s1_move) begin
            if (r_s1.emit) begin
                r_colour_acc  <= 8'h00;
                r_outline_acc <= 8'h00;
            end else begin
                r_colour_acc  <= n_colour_acc;
                r_outline_acc <= n_outline_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (s1_move && r_s1.emit) begin
            r_m_tvalid <= 1'b1;
        end else if (m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move && r_s1.emit) begin
            r_m_tdata <= {7'b0, r_s1.byte_col, r_s1.row_idx, n_outline_acc, n_colour_acc};
        end
    end

    assign m_tvalid = r_m_tvalid;
    assign m_tdata  = r_m_tdata;

endmodule

// ----- src/gdsp_checker.sv -----
`include "grey_dither_sprite_packer_core_defines.svh"

module gdsp_checker #(
    parameter int IMAGE_HEIGHT = 42
)
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // a stalled result stays put
    `GDSP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // a black pixel never carries a colour code
    `GDSP_ASSERT_IMPL(a_pairs_disjoint, i_clk, i_rst_n, m_tvalid, (m_tdata[7:0] & m_tdata[15:8]) == 8'h00, "colour and outline overlap")

    // outline pairs are all or nothing
    `GDSP_ASSERT_IMPL(a_outline_pairs, i_clk, i_rst_n, m_tvalid, (m_tdata[15] == m_tdata[14]) && (m_tdata[13] == m_tdata[12]) && (m_tdata[11] == m_tdata[10]) && (m_tdata[9] == m_tdata[8]), "outline pair split")

    // row stays inside the image
    `GDSP_ASSERT_IMPL(a_row_range, i_clk, i_rst_n, m_tvalid, (IMAGE_HEIGHT > 64) || (m_tdata[21:16] < IMAGE_HEIGHT), "row index beyond image height")

endmodule

bind grey_dither_sprite_packer_core gdsp_checker #(
    .IMAGE_HEIGHT (IMAGE_HEIGHT)
) u_gdsp_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
